// ----- rtl/core/sliding_log_rate_limiter_defines.svh -----
// Assertion helpers for the rate limiter core.
`ifndef SLIDING_LOG_RATE_LIMITER_DEFINES_SVH
`define SLIDING_LOG_RATE_LIMITER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked at every rising clock edge outside reset.
`define SLRL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("slrl assertion failed");
// Condition in one cycle implies a consequence in the next.
`define SLRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slrl assertion failed");
`else
`define SLRL_ASSERT(lbl, clk, rstn, prop)
`define SLRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/slrl_pkg.sv -----
package slrl_pkg;

  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned WAIT_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 9;

  localparam logic [TIME_BITS-1:0] SECOND_US   = 48'd1000000;
  localparam logic [TIME_BITS-1:0] MINUTE_US   = 48'd60000000;
  localparam logic [WAIT_W-1:0]    SECOND_WAIT = 20'd1000000;
  localparam logic [CNT_W-1:0]     CNT_MAX     = 9'h1FF;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PS_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PM_LIMIT = 2'd2;

  localparam logic             ENABLE_RST   = 1'b1;
  localparam logic [CFG_W-1:0] PS_LIMIT_RST = 9'd10;
  localparam logic [CFG_W-1:0] PM_LIMIT_RST = 9'd256;

  typedef struct packed {
    logic                 kind;
    logic [TIME_BITS-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic              log_full;
    logic [CNT_W-1:0]  count_last_second;
    logic [CNT_W-1:0]  count_last_minute;
    logic [WAIT_W-1:0] wait_us;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic prune_rd;
    logic pop;
    logic scan_init;
    logic scan_rd;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enable;
    logic held_zero;
    logic too_old;
    logic scan_done;
  } dp_sts_t;

endpackage

// ----- rtl/core/slrl_ctrl.sv -----
module slrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              kind_i,
  output logic              busy_o,
  output slrl_pkg::dp_cmd_t cmd_o,
  input  slrl_pkg::dp_sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_PRUNE_RD = 6'b000010,
    ST_PRUNE_CK = 6'b000100,
    ST_SCAN_SET = 6'b001000,
    ST_SCAN     = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          // only an enforced acquire prunes the log
          state_d = (sts_i.enable && kind_i) ? ST_PRUNE_RD : ST_SCAN_SET;
        end
      end
      ST_PRUNE_RD: begin
        if (sts_i.held_zero) begin
          state_d = ST_SCAN_SET;
        end else begin
          cmd_o.prune_rd = 1'b1;
          state_d        = ST_PRUNE_CK;
        end
      end
      ST_PRUNE_CK: begin
        if (sts_i.too_old) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_PRUNE_RD;
        end else begin
          state_d = ST_SCAN_SET;
        end
      end
      ST_SCAN_SET: begin
        cmd_o.scan_init = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        // last read data is folded in during the cycle that sees scan_done
        if (sts_i.scan_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- rtl/core/slrl_dp.sv -----
`include "sliding_log_rate_limiter_defines.svh"

module slrl_dp #(
  parameter int unsigned LOG_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [slrl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [slrl_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  slrl_pkg::in_item_t                  item_i,
  input  slrl_pkg::dp_cmd_t                   cmd_i,
  output slrl_pkg::dp_sts_t                   sts_o,
  output logic                                done_o,
  output slrl_pkg::out_item_t                 result_o
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned EW = (CW > slrl_pkg::CNT_W) ? CW : slrl_pkg::CNT_W;
  localparam int unsigned SW = CW + 1;
  localparam int unsigned TB = slrl_pkg::TIME_BITS;
  localparam int unsigned WW = slrl_pkg::WAIT_W;

  function automatic logic [slrl_pkg::CNT_W-1:0] sat_cnt(input logic [CW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return (e > EW'(slrl_pkg::CNT_MAX)) ? slrl_pkg::CNT_MAX : e[slrl_pkg::CNT_W-1:0];
  endfunction

  // configuration
  logic                       enable_q;
  logic [slrl_pkg::CFG_W-1:0] ps_lim_q, pm_lim_q;

  // item being worked on
  logic          kind_q;
  logic [TB-1:0] now_q;

  // ring bookkeeping
  logic [AW-1:0] oldest_q, ptr_q;
  logic [CW-1:0] held_q, left_q;

  // log memory and its read register
  logic [TB-1:0] mem_q [LOG_DEPTH];
  logic [TB-1:0] rd_q;
  logic          scan_vld_q;

  // scan accumulators
  logic [CW-1:0] sec_q, min_q;
  logic          found_q;
  logic [WW-1:0] first_wait_q;

  logic                done_q;
  slrl_pkg::out_item_t result_q;

  logic [TB-1:0] age;
  logic          age_sec, age_min;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_slot;
  logic          held_full, lim_ok, logged, log_we;
  logic [CW-1:0] sec_after, min_after;
  logic          wait_on;
  slrl_pkg::out_item_t result_d;

  assign age     = now_q - rd_q;
  assign age_sec = (age < slrl_pkg::SECOND_US);
  assign age_min = (age < slrl_pkg::MINUTE_US);

  assign rd_en   = cmd_i.prune_rd | cmd_i.scan_rd;
  assign rd_addr = cmd_i.prune_rd ? oldest_q : ptr_q;

  // slot after the newest entry: (oldest + held) mod depth
  always_comb begin
    tail_sum = SW'(oldest_q) + SW'(held_q);
    if (tail_sum >= SW'(LOG_DEPTH)) begin
      tail_sum = tail_sum - SW'(LOG_DEPTH);
    end
    tail_slot = tail_sum[AW-1:0];
  end

  assign held_full = (held_q == CW'(LOG_DEPTH));
  assign lim_ok    = kind_q && enable_q
                     && (EW'(sec_q) < EW'(ps_lim_q))
                     && (EW'(min_q) < EW'(pm_lim_q));
  assign logged    = lim_ok && !held_full;
  assign log_we    = cmd_i.finish && logged;
  assign sec_after = sec_q + CW'(logged);
  assign min_after = min_q + CW'(logged);
  assign wait_on   = enable_q && ((held_q != '0) || logged)
                     && (EW'(sec_after) >= EW'(ps_lim_q));

  always_comb begin
    result_d.granted           = !enable_q || logged;
    result_d.log_full          = lim_ok && held_full;
    result_d.count_last_second = sat_cnt(sec_after);
    result_d.count_last_minute = sat_cnt(min_after);
    if (!wait_on) begin
      result_d.wait_us = '0;
    end else if (found_q) begin
      result_d.wait_us = first_wait_q;
    end else if (logged) begin
      // the new entry is the first young one, age zero
      result_d.wait_us = slrl_pkg::SECOND_WAIT;
    end else begin
      result_d.wait_us = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (log_we) begin
      mem_q[tail_slot] <= now_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= slrl_pkg::ENABLE_RST;
      ps_lim_q   <= slrl_pkg::PS_LIMIT_RST;
      pm_lim_q   <= slrl_pkg::PM_LIMIT_RST;
      oldest_q   <= '0;
      held_q     <= '0;
      ptr_q      <= '0;
      left_q     <= '0;
      scan_vld_q <= 1'b0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          slrl_pkg::CFG_ENABLE:   enable_q <= cfg_wdata_i[0];
          slrl_pkg::CFG_PS_LIMIT: ps_lim_q <= cfg_wdata_i;
          slrl_pkg::CFG_PM_LIMIT: pm_lim_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      scan_vld_q <= cmd_i.scan_rd;
      done_q     <= cmd_i.finish;
      if (cmd_i.pop) begin
        oldest_q <= (oldest_q == AW'(LOG_DEPTH - 1)) ? '0 : oldest_q + AW'(1);
        held_q   <= held_q - CW'(1);
      end
      if (log_we) begin
        held_q <= held_q + CW'(1);
      end
      if (cmd_i.scan_init) begin
        ptr_q   <= oldest_q;
        left_q  <= held_q;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_rd) begin
        ptr_q  <= (ptr_q == AW'(LOG_DEPTH - 1)) ? '0 : ptr_q + AW'(1);
        left_q <= left_q - CW'(1);
      end
      if (scan_vld_q && age_sec) begin
        found_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= item_i.kind;
      now_q  <= item_i.now_us;
    end
    if (cmd_i.scan_init) begin
      sec_q <= '0;
      min_q <= '0;
    end else if (scan_vld_q) begin
      sec_q <= sec_q + CW'(age_sec);
      min_q <= min_q + CW'(age_min);
    end
    if (scan_vld_q && age_sec && !found_q) begin
      first_wait_q <= slrl_pkg::SECOND_WAIT - age[WW-1:0];
    end
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  assign sts_o.enable    = enable_q;
  assign sts_o.held_zero = (held_q == '0);
  assign sts_o.too_old   = (age > slrl_pkg::MINUTE_US);
  assign sts_o.scan_done = (left_q == '0);

  assign done_o   = done_q;
  assign result_o = result_q;

  `SLRL_ASSERT(a_held_bound, clk_i, rst_ni, held_q <= CW'(LOG_DEPTH))
  `SLRL_ASSERT(a_pop_nonempty, clk_i, rst_ni, cmd_i.pop |-> (held_q != '0))
  `SLRL_ASSERT(a_grant_or_full, clk_i, rst_ni, done_q |-> !(result_q.granted && result_q.log_full))
  `SLRL_ASSERT(a_wait_young, clk_i, rst_ni, (done_q && (result_q.wait_us != '0)) |-> (result_q.count_last_second != '0))
  `SLRL_ASSERT_NEXT(a_write_held, clk_i, rst_ni, log_we, held_q != '0)

endmodule

// ----- rtl/core/sliding_log_rate_limiter.sv -----
// Sliding-log rate limiter, one-second and sixty-second windows.
// Command channel: item_i (kind, now_us) is taken as a transaction on a rising
// edge with start high and busy low. busy stays high until the result is out.
// Result channel: result_o is valid for exactly one cycle while done_o is high;
// the receiver cannot hold it off, so it must take it in that cycle.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 enable,
// 1 per-second limit, 2 per-minute limit, 3 ignored); write only while busy
// is low.
// Sequence: an enforced acquire first pops log entries older than one minute
// from the oldest end, then scans every held entry and decides. A probe or
// any item while disabled skips pruning and goes straight to the scan. The
// log memory has one read port and every held entry is read once to count
// both windows. The next transaction may start in the cycle done_o is high.
// Reset: log empty, enable 1, per-second 10, per-minute 256; no clearing
// pass, stale log words are never read.
module sliding_log_rate_limiter #(
  parameter int unsigned LOG_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  slrl_pkg::in_item_t             item_i,
  output logic                           done_o,
  output slrl_pkg::out_item_t            result_o,
  input  logic                           cfg_we_i,
  input  logic [slrl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [slrl_pkg::CFG_W-1:0]     cfg_wdata_i
);

  slrl_pkg::dp_cmd_t cmd;
  slrl_pkg::dp_sts_t sts;

  // sequencer: prune, scan, decide
  slrl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (item_i.kind),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // log ring, window counters, config registers and result register
  slrl_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule
